FILE: src/assert_macros.svh
// Assertion macros used by the RTL core of the shock response peak filter.
// Each macro takes a label, a property expression and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while reset is high
`define CHK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also holds while reset is high
`define CHK_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/srpf_pkg.sv
// Package of the shock response peak filter: widths, register indexes.
// Used by the channel interfaces and the core; depends on nothing.
package srpf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 29;
  localparam int RESPONSE_BITS  = 32;
  localparam int COEF_BITS      = 32;
  localparam int PEAK_BITS      = 31;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Shared multiplier operand and product widths
  localparam int OP_W   = ((COEF_BITS > RESPONSE_BITS) ? COEF_BITS : RESPONSE_BITS) + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;
  // Square root operand width and iteration counter width
  localparam int SQ_W   = 2 * RESPONSE_BITS;
  localparam int CNT_W  = $clog2(RESPONSE_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FB_ONE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FB_TWO  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_IN_NOW  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_IN_PREV = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HORIZ_MODE   = 3'd4;

endpackage

FILE: src/srpf_if.sv
// Valid/ready channel interfaces of the shock response peak filter.
// Depends on srpf_pkg for field widths.
interface srpf_sample_if import srpf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_north;
  logic signed [SAMPLE_BITS-1:0] sample_east;
  logic                          last;
  modport source (output valid, sample_north, sample_east, last, input ready);
  modport sink (input valid, sample_north, sample_east, last, output ready);
endinterface

interface srpf_result_if import srpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PEAK_BITS-1:0] peak_response;
  logic                 saturated;
  modport source (output valid, peak_response, saturated, input ready);
  modport sink (input valid, peak_response, saturated, output ready);
endinterface

interface srpf_cfg_if import srpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/shock_response_peak_filter_core.sv
// Shock response peak filter core: one shared multiplier under a sequencer.
// Depends on srpf_pkg, srpf_if.sv and assert_macros.svh.
//
// Usage:
//   cfg    : register writes (index, data), always ready. Write only while idle.
//   sample : one acceleration sample per transaction (north, east, last).
//   result : one transaction per record, on the sample marked last, with the
//            saturated peak and the sticky saturation flag.
// Timing: one sample at a time; sample.ready is high only while idle.
//   The first two samples of a record go straight to the update state.
//   Later samples: two channels of four products each through the single
//   33x33 multiplier, with multiply and accumulate as separate states.
//   Horizontal mode adds the two squares and the bit-serial square root.
//   A sample marked last then passes through the emit state.
//   The result register frees the filter: a new sample is taken while a
//   result waits. If a second result is due before the first is taken,
//   the core holds in its emit state until result.ready.
// Reset (rst, synchronous): coefficients and mode to 0, record cleared,
//   result channel empty.
`include "assert_macros.svh"

module shock_response_peak_filter_core import srpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  srpf_cfg_if.sink     cfg,
  srpf_sample_if.sink  sample,
  srpf_result_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_RND, S_SQMUL, S_SQACC, S_SQRT, S_UPD, S_EMIT
  } state_t;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RESP_MAX =
    {{(ACC_W-RESPONSE_BITS+1){1'b0}}, {(RESPONSE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] RESP_MIN = ~RESP_MAX;
  localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

  state_t state;

  // Configuration registers
  logic signed [COEF_BITS-1:0] coef_fb_one, coef_fb_two, coef_in_now, coef_in_prev;
  logic                        horizontal_mode;

  // Record state
  logic signed [SAMPLE_BITS-1:0]   prev_north, prev_east;
  logic signed [RESPONSE_BITS-1:0] resp_north_one, resp_north_two;
  logic signed [RESPONSE_BITS-1:0] resp_east_one, resp_east_two;
  logic [1:0]                      sample_index;
  logic [RESPONSE_BITS-1:0]        peak_store;
  logic                            overflow_seen;

  // Working registers of the current sample
  logic signed [SAMPLE_BITS-1:0]   x_north, x_east;
  logic                            last_r;
  logic                            chan;
  logic [1:0]                      term;
  logic signed [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]         acc;
  logic signed [RESPONSE_BITS-1:0] rn_new, re_new;
  logic                            sat_n, sat_e;
  logic [RESPONSE_BITS-1:0]        mag;
  logic [SQ_W-1:0]                 sq_rem, sq_root, sq_bit;
  logic [CNT_W-1:0]                sq_cnt;

  // Result register
  logic                 out_valid;
  logic [PEAK_BITS-1:0] out_peak;
  logic                 out_sat;

  logic signed [OP_W-1:0]          op_a, op_b;
  logic signed [ACC_W-1:0]         shifted;
  logic signed [RESPONSE_BITS-1:0] rnd_val;
  logic                            rnd_sat;
  logic [RESPONSE_BITS-1:0]        abs_n, abs_e;
  logic [SQ_W-1:0]                 sq_trial;
  logic                            sq_take;
  logic [SQ_W-1:0]                 sq_root_next;
  logic [RESPONSE_BITS-1:0]        peak_next;
  logic                            ovf_next;
  logic                            sample_acc, out_free;

  assign cfg.ready     = 1'b1;
  assign sample.ready  = (state == S_IDLE);
  assign sample_acc    = sample.valid && sample.ready;
  assign result.valid  = out_valid;
  assign result.peak_response = out_peak;
  assign result.saturated     = out_sat;
  assign out_free      = !out_valid || result.ready;

  // Magnitudes of the new responses
  assign abs_n = rn_new[RESPONSE_BITS-1] ? RESPONSE_BITS'(-rn_new) : RESPONSE_BITS'(rn_new);
  assign abs_e = re_new[RESPONSE_BITS-1] ? RESPONSE_BITS'(-re_new) : RESPONSE_BITS'(re_new);

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_SQMUL) begin
      op_a = term[0] ? OP_W'(abs_e) : OP_W'(abs_n);
      op_b = op_a;
    end else begin
      case (term)
        2'd0: begin
          op_a = OP_W'(coef_fb_one);
          op_b = chan ? OP_W'(resp_east_one) : OP_W'(resp_north_one);
        end
        2'd1: begin
          op_a = -OP_W'(coef_fb_two);
          op_b = chan ? OP_W'(resp_east_two) : OP_W'(resp_north_two);
        end
        2'd2: begin
          op_a = OP_W'(coef_in_now);
          op_b = chan ? OP_W'(x_east) : OP_W'(x_north);
        end
        default: begin
          op_a = OP_W'(coef_in_prev);
          op_b = chan ? OP_W'(prev_east) : OP_W'(prev_north);
        end
      endcase
    end
  end

  // Round, scale and saturate the accumulated sum
  always_comb begin
    shifted = acc >>> COEF_FRAC_BITS;
    rnd_sat = 1'b0;
    rnd_val = RESPONSE_BITS'(shifted);
    if (shifted > RESP_MAX) begin
      rnd_sat = 1'b1;
      rnd_val = RESPONSE_BITS'(RESP_MAX);
    end else if (shifted < RESP_MIN) begin
      rnd_sat = 1'b1;
      rnd_val = RESPONSE_BITS'(RESP_MIN);
    end
  end

  // One step of the digit-by-digit square root
  always_comb begin
    sq_trial     = sq_root + sq_bit;
    sq_take      = (sq_rem >= sq_trial);
    sq_root_next = sq_take ? ((sq_root >> 1) + sq_bit) : (sq_root >> 1);
  end

  // Peak and sticky flag after this sample
  assign peak_next = (mag > peak_store) ? mag : peak_store;
  assign ovf_next  = overflow_seen || sat_n || (horizontal_mode && sat_e);

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      coef_fb_one     <= '0;
      coef_fb_two     <= '0;
      coef_in_now     <= '0;
      coef_in_prev    <= '0;
      horizontal_mode <= 1'b0;
      prev_north      <= '0;
      prev_east       <= '0;
      resp_north_one  <= '0;
      resp_north_two  <= '0;
      resp_east_one   <= '0;
      resp_east_two   <= '0;
      sample_index    <= '0;
      peak_store      <= '0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
      chan            <= 1'b0;
      term            <= '0;
      sq_cnt          <= '0;
    end else begin
      // configuration transaction
      if (cfg.valid) begin
        case (cfg.index)
          REG_COEF_FB_ONE:  coef_fb_one     <= COEF_BITS'(cfg.data);
          REG_COEF_FB_TWO:  coef_fb_two     <= COEF_BITS'(cfg.data);
          REG_COEF_IN_NOW:  coef_in_now     <= COEF_BITS'(cfg.data);
          REG_COEF_IN_PREV: coef_in_prev    <= COEF_BITS'(cfg.data);
          REG_HORIZ_MODE:   horizontal_mode <= cfg.data[0];
          default: ;
        endcase
      end

      // result taken; the emit state loads the register itself
      if (out_valid && result.ready && state != S_EMIT) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample_acc) begin
            x_north <= sample.sample_north;
            x_east  <= sample.sample_east;
            last_r  <= sample.last;
            chan    <= 1'b0;
            term    <= '0;
            acc     <= HALF;
            if (sample_index == 2'd2) begin
              state <= S_MUL;
            end else begin
              rn_new <= '0;
              re_new <= '0;
              sat_n  <= 1'b0;
              sat_e  <= 1'b0;
              mag    <= '0;
              state  <= S_UPD;
            end
          end
        end
        S_MUL: begin
          prod  <= op_a * op_b;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + ACC_W'(prod);
          if (term == 2'd3) begin
            state <= S_RND;
          end else begin
            term  <= term + 2'd1;
            state <= S_MUL;
          end
        end
        S_RND: begin
          term <= '0;
          if (!chan) begin
            rn_new <= rnd_val;
            sat_n  <= rnd_sat;
            chan   <= 1'b1;
            acc    <= HALF;
            state  <= S_MUL;
          end else begin
            re_new <= rnd_val;
            sat_e  <= rnd_sat;
            acc    <= '0;
            if (horizontal_mode) begin
              state <= S_SQMUL;
            end else begin
              mag   <= abs_n;
              state <= S_UPD;
            end
          end
        end
        S_SQMUL: begin
          prod  <= op_a * op_b;
          state <= S_SQACC;
        end
        S_SQACC: begin
          if (term[0]) begin
            sq_rem  <= SQ_W'(acc + ACC_W'(prod));
            sq_root <= '0;
            sq_bit  <= SQ_BIT_INIT;
            sq_cnt  <= CNT_W'(RESPONSE_BITS - 1);
            state   <= S_SQRT;
          end else begin
            acc   <= acc + ACC_W'(prod);
            term  <= 2'd1;
            state <= S_SQMUL;
          end
        end
        S_SQRT: begin
          if (sq_take) sq_rem <= sq_rem - sq_trial;
          sq_root <= sq_root_next;
          sq_bit  <= sq_bit >> 2;
          if (sq_cnt == '0) begin
            mag   <= RESPONSE_BITS'(sq_root_next);
            state <= S_UPD;
          end else begin
            sq_cnt <= sq_cnt - CNT_W'(1);
          end
        end
        S_UPD: begin
          peak_store     <= peak_next;
          overflow_seen  <= ovf_next;
          resp_north_two <= resp_north_one;
          resp_north_one <= rn_new;
          resp_east_two  <= resp_east_one;
          resp_east_one  <= re_new;
          prev_north     <= x_north;
          prev_east      <= x_east;
          if (sample_index != 2'd2) sample_index <= sample_index + 2'd1;
          state <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_peak       <= ((peak_store >> PEAK_BITS) != '0) ? '1
                              : PEAK_BITS'(peak_store);
            out_sat        <= overflow_seen || ((peak_store >> PEAK_BITS) != '0);
            prev_north     <= '0;
            prev_east      <= '0;
            resp_north_one <= '0;
            resp_north_two <= '0;
            resp_east_one  <= '0;
            resp_east_two  <= '0;
            sample_index   <= '0;
            peak_store     <= '0;
            overflow_seen  <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  `CHK_CLK(a_index_saturates, sample_index != 2'd3, "sample index passed two")
  `CHK_CLK(a_startup_skips_filter,
    (sample_acc && sample_index != 2'd2) |=> (state == S_UPD),
    "start of record sample entered the filter")
  `CHK_CLK(a_result_only_on_last, $rose(out_valid) |-> $past(state == S_EMIT),
    "result raised outside the emit step")
  `CHK_CLK(a_sqrt_only_horizontal, (state == S_SQRT) |-> horizontal_mode,
    "square root running outside horizontal mode")

endmodule
